>>> rtl/lpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice path counter package
// Shared widths, the link carried between neighboring cells and the
// controller state type.
// ----------------------------------------------------------------------------
package lpc_pkg;

   localparam int DIM_W   = 6;
   localparam int COUNT_W = 59;
   localparam int CELL_W  = 64;
   localparam int STEP_W  = 7;

   typedef struct packed {
      logic              en;
      logic [CELL_W-1:0] val;
   } link_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

endpackage

>>> rtl/lattice_path_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice path counter
// Counts monotone right/down paths across a rows by cols grid with a chain of
// adder cells, one per column after the first, swept by a diagonal update wave.
// ----------------------------------------------------------------------------
// The result is set by the update wave crossing rows - 1 rows and cols - 1
// cells; a zero dimension skips the wave. Items are not overlapped: a new
// item is taken only after the last result is written to the output register.
// One item is in flight at a time; a finished result waits in the output
// register while the next item is taken. Reset is synchronous and clears the
// controller and the output valid; cell contents are reloaded for every item.
module lattice_path_counter #(
   parameter int MAX_DIM = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lpc_pkg::DIM_W-1:0]   req_rows,
   input  logic [lpc_pkg::DIM_W-1:0]   req_cols,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lpc_pkg::COUNT_W-1:0] rsp_path_count
);

   localparam int IDX_W = $clog2(MAX_DIM);
   localparam logic [lpc_pkg::DIM_W-1:0] DIM_MAX = lpc_pkg::DIM_W'(MAX_DIM);

   lpc_pkg::state_type state_ff, state_in;
   logic [lpc_pkg::DIM_W-1:0]   rows_ff, rows_in;
   logic [lpc_pkg::DIM_W-1:0]   cols_ff, cols_in;
   logic                        zero_ff, zero_in;
   logic [lpc_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lpc_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [lpc_pkg::DIM_W-1:0]   rows_sat, cols_sat;
   logic                        req_xfer;
   logic                        start;
   logic                        row_en;
   logic [lpc_pkg::STEP_W-1:0]  total;
   logic                        finish;
   logic                        out_free;
   logic [IDX_W-1:0]            sel_idx;
   logic [lpc_pkg::CELL_W-1:0]  sel_val;
   logic [lpc_pkg::COUNT_W-1:0] sel_count;

   lpc_pkg::link_type link [MAX_DIM];

   assign rows_sat = (req_rows > DIM_MAX) ? DIM_MAX : req_rows;
   assign cols_sat = (req_cols > DIM_MAX) ? DIM_MAX : req_cols;

   assign req_ready = (state_ff == lpc_pkg::ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign start     = req_xfer;

   assign total  = lpc_pkg::STEP_W'(rows_ff) + lpc_pkg::STEP_W'(cols_ff)
                   - lpc_pkg::STEP_W'(2);
   assign row_en = (state_ff == lpc_pkg::ST_RUN) && !zero_ff
                   && (step_ff <= lpc_pkg::STEP_W'(rows_ff) - lpc_pkg::STEP_W'(1));
   assign finish = (state_ff == lpc_pkg::ST_RUN) && (zero_ff || (step_ff > total));

   assign link[0].en  = row_en;
   assign link[0].val = lpc_pkg::CELL_W'(1);

   for (genvar j = 1; j < MAX_DIM; j++) begin : g_cell
      lpc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .start     (start),
         .left_in   (link[j-1]),
         .right_out (link[j])
      );
   end

   assign sel_idx   = IDX_W'(cols_ff - lpc_pkg::DIM_W'(1));
   assign sel_val   = link[sel_idx].val;
   assign sel_count = (sel_val[lpc_pkg::CELL_W-1:lpc_pkg::COUNT_W] != '0)
                      ? {lpc_pkg::COUNT_W{1'b1}} : sel_val[lpc_pkg::COUNT_W-1:0];

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      zero_in      = zero_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      unique case (state_ff)
         lpc_pkg::ST_IDLE: begin
            if (req_xfer) begin
               rows_in  = rows_sat;
               cols_in  = cols_sat;
               zero_in  = (rows_sat == '0) || (cols_sat == '0);
               step_in  = lpc_pkg::STEP_W'(1);
               state_in = lpc_pkg::ST_RUN;
            end
         end
         lpc_pkg::ST_RUN: begin
            if (finish) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = zero_ff ? '0 : sel_count;
                  state_in     = lpc_pkg::ST_IDLE;
               end
            end else begin
               step_in = step_ff + lpc_pkg::STEP_W'(1);
            end
         end
         default: begin
            state_in = lpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rows_ff      <= rows_in;
      cols_ff      <= cols_in;
      zero_ff      <= zero_in;
      step_ff      <= step_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_count_ff;

endmodule

>>> rtl/lpc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice path counter cell
// Holds one column's partial count and adds its left neighbor's count when
// the update wave reaches it, then passes the wave on to the right.
// ----------------------------------------------------------------------------
module lpc_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  lpc_pkg::link_type left_in,
   output lpc_pkg::link_type right_out
);

   logic                      en_ff;
   logic                      en_in;
   logic [lpc_pkg::CELL_W-1:0] val_ff;
   logic [lpc_pkg::CELL_W-1:0] val_in;
   logic [lpc_pkg::CELL_W:0]   sum;

   assign sum = {1'b0, val_ff} + {1'b0, left_in.val};

   always_comb begin
      en_in  = left_in.en && !start;
      val_in = val_ff;
      if (start) begin
         val_in = lpc_pkg::CELL_W'(1);
      end else if (left_in.en) begin
         val_in = sum[lpc_pkg::CELL_W] ? {lpc_pkg::CELL_W{1'b1}}
                                       : sum[lpc_pkg::CELL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
      end else begin
         en_ff <= en_in;
      end
      val_ff <= val_in;
   end

   assign right_out.en  = en_ff;
   assign right_out.val = val_ff;

endmodule

>>> rtl/lpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice path counter checker
// Port-level checks of the result channel and of the one-item-at-a-time
// sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module lpc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [lpc_pkg::COUNT_W-1:0] rsp_path_count
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result dropped before its transfer.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_path_count))
      else $error("Result changed while stalled.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Input taken while an item is still being counted.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(rsp_valid && !$past(rsp_valid)))
      else $error("Result appeared in the cycle after the input transfer.");

endmodule

bind lattice_path_counter lpc_checker u_lpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_path_count (rsp_path_count)
);
